// ===== rtl/signed_integer_to_radix_digits_core_defines.svh =====
// Assertion macros shared by the checker of the radix digit core.
`ifndef SIGNED_INTEGER_TO_RADIX_DIGITS_CORE_DEFINES_SVH
`define SIGNED_INTEGER_TO_RADIX_DIGITS_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, quiet during reset.
`define SITRD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, quiet during reset.
`define SITRD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/sitrd_pkg.sv =====
// Shared constants, types and the symbol lookup for the radix digit core.
package sitrd_pkg;

	localparam int MAX_SYMBOLS   = 16;
	localparam int DIGIT_W       = $clog2(MAX_SYMBOLS);
	localparam int SYMBOL_W      = 8;
	localparam int VALUE_W       = 32;
	localparam int LEN_W         = 5;
	localparam int MAX_DIGITS    = 32;
	localparam int PTR_W         = $clog2(MAX_DIGITS);
	localparam int CNT_W         = PTR_W + 1;
	localparam int BITS_PER_STEP = 8;
	localparam int STEP_W        = $clog2(VALUE_W / BITS_PER_STEP);
	localparam int ADDR_W        = 5;
	localparam int DATA_W        = 64;

	localparam logic [SYMBOL_W-1:0] SIGN_MINUS = 8'd45;
	localparam logic [SYMBOL_W-1:0] SIGN_PLUS  = 8'd43;
	localparam logic [LEN_W-1:0]    MIN_BASE   = 5'd2;
	localparam logic [LEN_W-1:0]    MAX_BASE   = 5'd16;

	// Register indexes (byte address / 8)
	localparam logic [1:0] REG_BASE_LENGTH  = 2'd0;
	localparam logic [1:0] REG_SYMBOLS_LOW  = 2'd1;
	localparam logic [1:0] REG_SYMBOLS_HIGH = 2'd2;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load;
		logic div_step;
		logic digit_write;
		logic emit_sign;
		logic emit_digit;
	} cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic quot_zero;
		logic last_digit;
		logic neg;
	} status_t;

	// Symbol byte for a digit: low word holds digits 0..7, high word 8..15
	function automatic logic [SYMBOL_W-1:0] sym_at(
		input logic [DATA_W-1:0]  lo,
		input logic [DATA_W-1:0]  hi,
		input logic [DIGIT_W-1:0] idx
	);
		logic [DATA_W-1:0] word;
		word = idx[DIGIT_W-1] ? hi : lo;
		return word[idx[DIGIT_W-2:0]*SYMBOL_W +: SYMBOL_W];
	endfunction

endpackage

// ===== rtl/sitrd_regs.sv =====
// Configuration registers, APB access and symbol table validity check.
module sitrd_regs import sitrd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output logic [LEN_W-1:0]  base_length,
	output logic [DATA_W-1:0] sym_lo,
	output logic [DATA_W-1:0] sym_hi,
	output logic              base_valid
);

	logic [LEN_W-1:0]  len_q;
	logic [DATA_W-1:0] lo_q;
	logic [DATA_W-1:0] hi_q;
	logic              valid_q;
	logic              valid_d;
	logic              wr_en;
	logic [1:0]        reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[ADDR_W-1:ADDR_W-2];

	// Write registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			lo_q  <= '0;
			hi_q  <= '0;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_BASE_LENGTH:  len_q <= pwdata[LEN_W-1:0];
				REG_SYMBOLS_LOW:  lo_q  <= pwdata;
				REG_SYMBOLS_HIGH: hi_q  <= pwdata;
				default: ;
			endcase
		end
	end

	// Read back
	always_comb begin
		unique case (reg_idx)
			REG_BASE_LENGTH:  prdata = {{(DATA_W-LEN_W){1'b0}}, len_q};
			REG_SYMBOLS_LOW:  prdata = lo_q;
			REG_SYMBOLS_HIGH: prdata = hi_q;
			default:          prdata = '0;
		endcase
	end

	// Check length range, reserved sign symbols and duplicates
	always_comb begin
		logic [SYMBOL_W-1:0] si;
		valid_d = (len_q >= MIN_BASE) && (len_q <= MAX_BASE);
		for (int i = 0; i < MAX_SYMBOLS; i++) begin
			si = sym_at(lo_q, hi_q, DIGIT_W'(i));
			if (LEN_W'(i) < len_q) begin
				if (si == SIGN_MINUS || si == SIGN_PLUS)
					valid_d = 1'b0;
				for (int j = 0; j < i; j++) begin
					if (sym_at(lo_q, hi_q, DIGIT_W'(j)) == si)
						valid_d = 1'b0;
				end
			end
		end
	end

	// Register the check result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else
			valid_q <= valid_d;
	end

	assign base_length = len_q;
	assign sym_lo      = lo_q;
	assign sym_hi      = hi_q;
	assign base_valid  = valid_q;

endmodule

// ===== rtl/sitrd_datapath.sv =====
// Magnitude, digit divider, digit buffer and output word register.
module sitrd_datapath import sitrd_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  cmd_t                      cmd,
	input  logic signed [VALUE_W-1:0] value,
	input  logic [LEN_W-1:0]          base_length,
	input  logic [DATA_W-1:0]         sym_lo,
	input  logic [DATA_W-1:0]         sym_hi,
	output status_t                   status,
	output logic                      strobe,
	output logic [SYMBOL_W-1:0]       character,
	output logic                      last_char
);

	logic [VALUE_W-1:0]  q_q;
	logic [DIGIT_W-1:0]  rem_q;
	logic                neg_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [DIGIT_W-1:0]  digit_q [MAX_DIGITS];
	logic                strobe_q;
	logic [SYMBOL_W-1:0] char_q;
	logic                last_q;

	logic [VALUE_W-1:0]       mag;
	logic [VALUE_W-1:0]       q_next;
	logic [DIGIT_W-1:0]       rem_next;
	logic [BITS_PER_STEP-1:0] qbits;
	logic [PTR_W-1:0]         rd_idx;

	// Magnitude of the input; the most negative value maps to 2^31 exactly
	assign mag = value[VALUE_W-1] ? (~value + VALUE_W'(1)) : value;

	// Divide by the base, one byte of the dividend per cycle
	always_comb begin
		logic [DIGIT_W:0] r;
		r = {1'b0, rem_q};
		for (int i = 0; i < BITS_PER_STEP; i++) begin
			r = {r[DIGIT_W-1:0], q_q[VALUE_W-1-i]};
			if (r >= base_length) begin
				r = r - base_length;
				qbits[BITS_PER_STEP-1-i] = 1'b1;
			end else begin
				qbits[BITS_PER_STEP-1-i] = 1'b0;
			end
		end
		rem_next = r[DIGIT_W-1:0];
	end

	assign q_next = {q_q[VALUE_W-BITS_PER_STEP-1:0], qbits};
	assign rd_idx = cnt_q[PTR_W-1:0] - PTR_W'(1);

	assign status.quot_zero  = (q_next == '0);
	assign status.last_digit = (cnt_q == CNT_W'(1));
	assign status.neg        = neg_q;

	// Dividend, remainder and digit store
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			q_q   <= mag;
			rem_q <= '0;
			neg_q <= value[VALUE_W-1];
		end else if (cmd.div_step) begin
			q_q   <= q_next;
			rem_q <= cmd.digit_write ? '0 : rem_next;
		end
		if (cmd.digit_write)
			digit_q[cnt_q[PTR_W-1:0]] <= rem_next;
		if (cmd.emit_sign || cmd.emit_digit) begin
			char_q <= cmd.emit_sign ? SIGN_MINUS : sym_at(sym_lo, sym_hi, digit_q[rd_idx]);
			last_q <= cmd.emit_digit && (cnt_q == CNT_W'(1));
		end
	end

	// Digit count and output strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= cmd.emit_sign | cmd.emit_digit;
			if (cmd.load)
				cnt_q <= '0;
			else if (cmd.digit_write)
				cnt_q <= cnt_q + CNT_W'(1);
			else if (cmd.emit_digit)
				cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	assign strobe    = strobe_q;
	assign character = char_q;
	assign last_char = last_q;

endmodule

// ===== rtl/sitrd_ctrl.sv =====
// Controller: sequences check, division, sign and digit output.
module sitrd_ctrl import sitrd_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  logic    base_valid,
	input  status_t status,
	output cmd_t    cmd,
	output logic    busy
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIV,
		ST_SIGN,
		ST_EMIT
	} state_t;

	state_t            state_q;
	state_t            state_d;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              digit_end;

	assign digit_end = (step_q == {STEP_W{1'b1}});

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (start) state_d = ST_CHECK;
			ST_CHECK: state_d = base_valid ? ST_DIV : ST_IDLE;
			ST_DIV: begin
				if (digit_end && status.quot_zero)
					state_d = status.neg ? ST_SIGN : ST_EMIT;
			end
			ST_SIGN:  state_d = ST_EMIT;
			ST_EMIT:  if (status.last_digit) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// Commands to the datapath
	always_comb begin
		cmd             = '0;
		cmd.load        = (state_q == ST_IDLE) && start;
		cmd.div_step    = (state_q == ST_DIV);
		cmd.digit_write = (state_q == ST_DIV) && digit_end;
		cmd.emit_sign   = (state_q == ST_SIGN);
		cmd.emit_digit  = (state_q == ST_EMIT);
	end

	// State, byte step counter and busy flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
			busy_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			busy_q  <= (state_d != ST_IDLE);
			if (state_q == ST_DIV)
				step_q <= step_q + STEP_W'(1);
			else
				step_q <= '0;
		end
	end

	assign busy = busy_q;

endmodule

// ===== rtl/signed_integer_to_radix_digits_core.sv =====
// A value has 1..32 digits. After start the core checks the symbol table, then divides
// by the base one dividend byte per cycle, producing digits least significant first;
// then the sign (negative values only) and the digits leave one word per cycle,
// most significant digit first.
// Invalid symbol table: busy for one cycle after start, no words.
// Reset clears the configuration registers to zero (invalid table) and leaves the core idle.
module signed_integer_to_radix_digits_core import sitrd_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [ADDR_W-1:0]         paddr,
	input  logic [DATA_W-1:0]         pwdata,
	output logic [DATA_W-1:0]         prdata,
	output logic                      pready,
	input  logic                      start,
	output logic                      busy,
	input  logic signed [VALUE_W-1:0] value,
	output logic                      strobe,
	output logic [SYMBOL_W-1:0]       character,
	output logic                      last_char
);

	logic [LEN_W-1:0]  base_length;
	logic [DATA_W-1:0] sym_lo;
	logic [DATA_W-1:0] sym_hi;
	logic              base_valid;
	cmd_t              cmd;
	status_t           status;

	sitrd_regs u_regs (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.base_length (base_length),
		.sym_lo      (sym_lo),
		.sym_hi      (sym_hi),
		.base_valid  (base_valid)
	);

	sitrd_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.base_valid (base_valid),
		.status     (status),
		.cmd        (cmd),
		.busy       (busy)
	);

	sitrd_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.value       (value),
		.base_length (base_length),
		.sym_lo      (sym_lo),
		.sym_hi      (sym_hi),
		.status      (status),
		.strobe      (strobe),
		.character   (character),
		.last_char   (last_char)
	);

endmodule

// ===== rtl/sitrd_checker.sv =====
// Port-level checker for the radix digit core, bound to the top level.
`include "signed_integer_to_radix_digits_core_defines.svh"

module sitrd_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic strobe,
	input logic last_char
);

	// Accepted start raises busy
	`SITRD_ASSERT_NEXT(a_busy_after_start, start && !busy, busy, "busy not raised after start")

	// No output word in the cycle after a start
	`SITRD_ASSERT_NEXT(a_quiet_after_start, start && !busy, !strobe, "word right after start")

	// Text runs without gaps until its last word
	`SITRD_ASSERT_NEXT(a_text_contiguous, strobe && !last_char, strobe, "gap inside text")

	// Only the last word may appear while idle
	`SITRD_ASSERT_NOW(a_busy_mid_text, strobe && !last_char, busy, "busy low inside text")

endmodule

bind signed_integer_to_radix_digits_core sitrd_checker u_sitrd_checker (.*);
